// ----- rtl/core/ffha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and control structures of the first-fit heap
// allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int MAX_NODES    = 64;
	localparam int NODE_W       = 6;
	localparam int SIZE_W       = 13;
	localparam int MAX_GRANULES = 4096;
	localparam int GRAN_SHIFT   = 4;
	localparam int BYTE_W       = 16;
	localparam int BYTES_W      = 17;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_NO_SLOT   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic              used;
		logic [NODE_W-1:0] next;
		logic [SIZE_W-1:0] size;
	} node_t;

	localparam int NODE_BITS = 1 + NODE_W + SIZE_W;

	typedef struct packed {
		logic    load;
		logic    walk;
		logic    step;
		logic    rd_next;
		logic    scan_step;
		logic    wr_split_e;
		logic    wr_split_s;
		logic    wr_mark;
		logic    wr_merge;
		logic    set_res;
		status_t res_status;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    hit;
		logic    last;
		logic    oob;
		logic    bigger;
		logic    cur_used;
		logic    slot_free;
		logic    scan_end;
		logic    out_free;
	} stat_t;

endpackage

// ----- rtl/core/ffha_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] request_bytes;
	logic [15:0] offset;

	modport source (output valid, action, request_bytes, offset, input ready);
	modport sink (input valid, action, request_bytes, offset, output ready);
endinterface

interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] block_offset;
	logic [16:0] block_bytes;
	logic [12:0] free_granules;

	modport source (output valid, status, block_offset, block_bytes, free_granules,
		input ready);
	modport sink (input valid, status, block_offset, block_bytes, free_granules,
		output ready);
endinterface

// ----- rtl/core/ffha_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ----- rtl/core/ffha_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: block table, list walk registers, slot scan, merge and result.
// ----------------------------------------------------------------------------
module ffha_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffha_pkg::cmd_t                cmd,
	output ffha_pkg::stat_t               st,
	input  logic [1:0]                    action,
	input  logic [15:0]                   request_bytes,
	input  logic [15:0]                   offset,
	input  logic                          cfg_we,
	input  logic [ffha_pkg::SIZE_W-1:0]   cfg_data,
	output logic [ffha_pkg::SIZE_W-1:0]   heap_granules,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [1:0]                    status,
	output logic [15:0]                   block_offset,
	output logic [16:0]                   block_bytes,
	output logic [12:0]                   free_granules
);
	import ffha_pkg::*;

	localparam int G_W = BYTE_W - GRAN_SHIFT;

	action_t               act_q;
	logic [SIZE_W-1:0]     need_q, start_q, free_total_q, heap_q;
	logic [G_W-1:0]        g_q;
	logic [NODE_W-1:0]     s_q, prev_q, e_q, rd_addr_q, rd_addr;
	logic                  has_prev_q;
	node_t                 s_word_q, prev_word_q, rd_word, cur, wr_word;
	logic [MAX_NODES-1:0]  occ_q, valid_q;
	logic [NODE_BITS-1:0]  rd_raw;
	logic                  wr_en;
	logic [NODE_W-1:0]     wr_addr;
	logic [BYTE_W:0]       req_sum;
	logic [SIZE_W-1:0]     need_raw, need_c;
	logic [SIZE_W:0]       start_end;
	logic                  merge_prev, merge_next;
	logic [SIZE_W-1:0]     m_size;
	logic [NODE_W-1:0]     m_next, base_addr;
	status_t               res_status_q;
	logic [BYTE_W-1:0]     res_boff_q;
	logic [BYTES_W-1:0]    res_bytes_q;
	logic                  res_ok;
	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [BYTE_W-1:0]     out_boff_q;
	logic [BYTES_W-1:0]    out_bytes_q;
	logic [SIZE_W-1:0]     out_free_q;

	assign rd_addr = cmd.rd_next ? cur.next : '0;

	ffha_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	assign rd_word = node_t'(rd_raw);

	always_comb begin
		if (valid_q[rd_addr_q]) begin
			cur = rd_word;
		end else begin
			cur.used = 1'b0;
			cur.next = '0;
			cur.size = (rd_addr_q == '0) ? heap_q : '0;
		end
	end

	assign req_sum  = {1'b0, request_bytes} + (BYTE_W+1)'((1 << GRAN_SHIFT) - 1);
	assign need_raw = SIZE_W'(req_sum >> GRAN_SHIFT);
	assign need_c   = (need_raw == '0) ? SIZE_W'(1) : need_raw;

	assign start_end = {1'b0, start_q} + {1'b0, cur.size};

	always_comb begin
		st.act       = act_q;
		st.hit       = (act_q == ACT_ALLOC) ? (!cur.used && need_q <= cur.size)
		                                    : ((SIZE_W+1)'(g_q) < start_end);
		st.last      = (cur.next == '0);
		st.oob       = SIZE_W'(g_q) >= heap_q;
		st.bigger    = cur.size > need_q;
		st.cur_used  = cur.used;
		st.slot_free = !occ_q[e_q];
		st.scan_end  = (e_q == NODE_W'(MAX_NODES - 1));
		st.out_free  = !out_valid_q || out_ready;
	end

	assign merge_prev = has_prev_q && !prev_word_q.used;
	assign merge_next = (s_word_q.next != '0) && !cur.used;
	assign base_addr  = merge_prev ? prev_q : s_q;
	assign m_next     = merge_next ? cur.next : s_word_q.next;
	assign m_size     = (merge_prev ? prev_word_q.size : '0) + s_word_q.size
	                  + (merge_next ? cur.size : '0);

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = s_q;
		wr_word = s_word_q;
		priority if (cmd.wr_split_e) begin
			wr_addr      = e_q;
			wr_word.used = 1'b0;
			wr_word.next = s_word_q.next;
			wr_word.size = s_word_q.size - need_q;
		end else if (cmd.wr_split_s) begin
			wr_word.used = 1'b1;
			wr_word.next = e_q;
			wr_word.size = need_q;
		end else if (cmd.wr_mark) begin
			wr_word.used = 1'b1;
		end else if (cmd.wr_merge) begin
			wr_addr      = base_addr;
			wr_word.used = 1'b0;
			wr_word.next = m_next;
			wr_word.size = m_size;
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;
		if (cmd.load) begin
			act_q      <= action_t'(action);
			need_q     <= need_c;
			g_q        <= G_W'(offset >> GRAN_SHIFT);
			s_q        <= '0;
			start_q    <= '0;
			has_prev_q <= 1'b0;
			e_q        <= '0;
		end else begin
			if (cmd.walk) begin
				s_word_q <= cur;
			end
			if (cmd.step) begin
				prev_q      <= s_q;
				prev_word_q <= cur;
				has_prev_q  <= 1'b1;
				start_q     <= start_q + cur.size;
				s_q         <= cur.next;
			end
			if (cmd.scan_step) begin
				e_q <= e_q + NODE_W'(1);
			end
		end
	end

	assign res_ok = (cmd.res_status == ST_OK);

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_boff_q   <= (res_ok && act_q == ACT_ALLOC)
			              ? BYTE_W'({start_q, {GRAN_SHIFT{1'b0}}}) : '0;
			if (res_ok && act_q == ACT_ALLOC) begin
				res_bytes_q <= BYTES_W'({need_q, {GRAN_SHIFT{1'b0}}});
			end else if (res_ok && act_q == ACT_QUERY) begin
				res_bytes_q <= BYTES_W'({cur.size, {GRAN_SHIFT{1'b0}}});
			end else begin
				res_bytes_q <= '0;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_boff_q   <= res_boff_q;
			out_bytes_q  <= res_bytes_q;
			out_free_q   <= free_total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q       <= SIZE_W'(MAX_GRANULES);
			free_total_q <= SIZE_W'(MAX_GRANULES);
			occ_q        <= MAX_NODES'(1);
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				heap_q       <= cfg_data;
				free_total_q <= cfg_data;
				occ_q        <= MAX_NODES'(1);
				valid_q      <= '0;
			end else begin
				if (wr_en) begin
					valid_q[wr_addr] <= 1'b1;
				end
				if (cmd.wr_split_e) begin
					occ_q[e_q] <= 1'b1;
				end
				if (cmd.wr_merge) begin
					if (merge_prev) begin
						occ_q[s_q] <= 1'b0;
					end
					if (merge_next) begin
						occ_q[s_word_q.next] <= 1'b0;
					end
				end
				if (cmd.wr_split_s || cmd.wr_mark) begin
					free_total_q <= free_total_q - need_q;
				end else if (cmd.wr_merge) begin
					free_total_q <= free_total_q + s_word_q.size;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign heap_granules = heap_q;
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign block_offset  = out_boff_q;
	assign block_bytes   = out_bytes_q;
	assign free_granules = out_free_q;
endmodule

// ----- rtl/core/ffha_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences the list walk, slot scan, table writes and response.
// ----------------------------------------------------------------------------
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ffha_pkg::stat_t st,
	output ffha_pkg::cmd_t  cmd
);
	import ffha_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_WALK    = 9'b000000010,
		S_SCAN    = 9'b000000100,
		S_SPLIT_E = 9'b000001000,
		S_SPLIT_S = 9'b000010000,
		S_MARK    = 9'b000100000,
		S_NBR     = 9'b001000000,
		S_RESP    = 9'b010000000,
		S_SPARE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk    = 1'b1;
				cmd.rd_next = 1'b1;
				if (st.act == ACT_NOP) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_RESP;
				end else if (st.act != ACT_ALLOC && st.oob) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d        = S_RESP;
				end else if (st.hit) begin
					if (st.act == ACT_ALLOC) begin
						state_d = st.bigger ? S_SCAN : S_MARK;
					end else if (st.act == ACT_FREE && st.cur_used) begin
						state_d = S_NBR;
					end else begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_RESP;
					end
				end else if (st.last) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = (st.act == ACT_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
					state_d        = S_RESP;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_SCAN: begin
				if (st.slot_free) begin
					state_d = S_SPLIT_E;
				end else if (st.scan_end) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_NO_SLOT;
					state_d        = S_RESP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SPLIT_E: begin
				cmd.wr_split_e = 1'b1;
				state_d        = S_SPLIT_S;
			end
			S_SPLIT_S: begin
				cmd.wr_split_s = 1'b1;
				cmd.set_res    = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_RESP;
			end
			S_MARK: begin
				cmd.wr_mark    = 1'b1;
				cmd.set_res    = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_RESP;
			end
			S_NBR: begin
				cmd.wr_merge   = 1'b1;
				cmd.set_res    = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ----- rtl/core/first_fit_heap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block splitting and neighbor coalescing.
// ----------------------------------------------------------------------------
// Request words arrive on req: allocate, free or size query. Each request
// gives exactly one response word on rsp with a status, the block offset and
// size in bytes, and the free granule count after the action.
// A request walks the address-ordered block list one slot per cycle from
// slot 0. After the walk, an allocate that splits scans for an empty slot
// and then writes the split-off block and the allocated block, an allocate
// that fits exactly marks its block used, and a free of a used block merges
// it with its free neighbors. One request is processed at a time.
// A new request is accepted as soon as the previous response is in the
// output register, even while the receiver stalls it; a stalled response
// holds its word and holds the controller at the response step.
// The APB register heap_granules at address 0 re-initializes the heap as one
// free block when written; write it only while the block is idle.
// Reset is asynchronous and leaves a 4096-granule heap with no allocations.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	ffha_req_if.sink                      req,
	ffha_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ffha_pkg::PADDR_W-1:0]  paddr,
	input  logic [ffha_pkg::PDATA_W-1:0]  pwdata,
	output logic [ffha_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ffha_pkg::*;

	cmd_t              cmd;
	stat_t             st;
	logic              reg_sel, cfg_we;
	logic [SIZE_W-1:0] wval, cfg_data, heap_granules;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == '0);
	assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? PDATA_W'(heap_granules) : '0;

	assign wval = pwdata[SIZE_W-1:0];
	always_comb begin
		priority if (wval == '0) begin
			cfg_data = SIZE_W'(1);
		end else if (wval > SIZE_W'(MAX_GRANULES)) begin
			cfg_data = SIZE_W'(MAX_GRANULES);
		end else begin
			cfg_data = wval;
		end
	end

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	ffha_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.action        (req.action),
		.request_bytes (req.request_bytes),
		.offset        (req.offset),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.heap_granules (heap_granules),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.status        (rsp.status),
		.block_offset  (rsp.block_offset),
		.block_bytes   (rsp.block_bytes),
		.free_granules (rsp.free_granules)
	);
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap allocator.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, every action and the no-fit and
// not-found codes, then random phases under several heap sizes mix allocate,
// free and size requests. Responses are checked against the table or a heap
// predictor, with random gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb;
	import ffha_pkg::*;

	typedef struct packed {
		status_t     st;
		logic [15:0] boff;
		logic [16:0] bbytes;
		logic [12:0] freeg;
	} heap_rsp_t;

	typedef struct {
		bit          wr_cfg;
		action_t     act;
		logic [15:0] rq;
		logic [15:0] of;
		bit          typed;
		heap_rsp_t   rsp;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ffha_req_if req_ch ();
	ffha_rsp_if rsp_ch ();

	first_fit_heap_allocator u_top (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	int unsigned heap_g;
	logic [SIZE_W-1:0] blk_size [MAX_NODES];
	logic [NODE_W-1:0] blk_next [MAX_NODES];
	bit blk_used [MAX_NODES];
	int unsigned free_tot;

	heap_rsp_t pending_rsp [$];
	int unsigned words_sent, words_got, mismatches, idle_cycles;
	bit no_gaps;
	int unsigned stall_cycles;

	function automatic void heap_reinit(logic [PDATA_W-1:0] v);
		int unsigned g;
		g = v & 32'h1FFF;
		if (g < 1) g = 1;
		if (g > MAX_GRANULES) g = MAX_GRANULES;
		heap_g = g;
		for (int i = 0; i < MAX_NODES; i++) begin
			blk_size[i] = '0;
			blk_next[i] = '0;
			blk_used[i] = 1'b0;
		end
		blk_size[0] = SIZE_W'(g);
		free_tot = g;
	endfunction

	function automatic heap_rsp_t heap_apply(action_t act, logic [15:0] rq, logic [15:0] of);
		heap_rsp_t r;
		int unsigned need, s, start, prv, e, g, n;
		bit found, has_prv;
		r = '{ST_OK, 16'd0, 17'd0, 13'd0};
		found = 0;
		has_prv = 0;
		s = 0;
		start = 0;
		prv = 0;
		if (act == ACT_ALLOC) begin
			need = (int'(rq) + 15) / 16;
			if (need == 0) need = 1;
			r.st = ST_NO_FIT;
			for (int k = 0; k < MAX_NODES; k++) begin
				if (!blk_used[s] && need <= blk_size[s]) begin
					found = 1;
					break;
				end
				if (blk_next[s] == 0) break;
				start += blk_size[s];
				s = blk_next[s];
			end
			if (found && blk_size[s] > need) begin
				for (e = 0; e < MAX_NODES; e++)
					if (blk_size[e] == 0) break;
				if (e >= MAX_NODES) begin
					r.st = ST_NO_SLOT;
					found = 0;
				end else begin
					blk_size[e] = SIZE_W'(blk_size[s] - need);
					blk_used[e] = 0;
					blk_next[e] = blk_next[s];
					blk_next[s] = NODE_W'(e);
					blk_size[s] = SIZE_W'(need);
				end
			end
			if (found) begin
				blk_used[s] = 1;
				free_tot -= need;
				r.st = ST_OK;
				r.boff = 16'(start * 16);
				r.bbytes = 17'(need * 16);
			end
		end else if (act == ACT_FREE || act == ACT_QUERY) begin
			g = of / 16;
			r.st = ST_NOT_FOUND;
			if (g < heap_g) begin
				for (int k = 0; k < MAX_NODES; k++) begin
					if (g >= start && g < start + blk_size[s]) begin
						found = 1;
						break;
					end
					if (blk_next[s] == 0) break;
					start += blk_size[s];
					prv = s;
					has_prv = 1;
					s = blk_next[s];
				end
			end
			if (found) begin
				r.st = ST_OK;
				if (act == ACT_QUERY) begin
					r.bbytes = 17'(blk_size[s] * 16);
				end else if (blk_used[s]) begin
					blk_used[s] = 0;
					free_tot += blk_size[s];
					if (has_prv && !blk_used[prv]) begin
						blk_size[prv] += blk_size[s];
						blk_next[prv] = blk_next[s];
						blk_size[s] = 0;
						blk_next[s] = 0;
						s = prv;
					end
					n = blk_next[s];
					if (n != 0 && !blk_used[n]) begin
						blk_size[s] += blk_size[n];
						blk_next[s] = blk_next[n];
						blk_size[n] = 0;
						blk_next[n] = 0;
					end
				end
			end
		end else begin
			r.st = ST_OK;
		end
		r.freeg = 13'(free_tot);
		return r;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (no_gaps || p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(action_t act, logic [15:0] rq, logic [15:0] of,
			bit typed, heap_rsp_t want);
		heap_rsp_t r;
		int unsigned gap;
		gap = gap_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.request_bytes <= rq;
		req_ch.offset <= of;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		r = heap_apply(act, rq, of);
		pending_rsp.push_back(typed ? want : r);
		words_sent++;
		idle_cycles = 0;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (words_got != words_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_heap(logic [PDATA_W-1:0] v);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		heap_reinit(v);
		idle_cycles = 0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_phase(logic [PDATA_W-1:0] cfg, int unsigned count);
		int unsigned p, span;
		logic [15:0] rq, of;
		action_t act;
		write_heap(cfg);
		for (int i = 0; i < count; i++) begin
			span = heap_g * 16;
			p = $urandom_range(0, 99);
			act = p < 45 ? ACT_ALLOC : p < 80 ? ACT_FREE : p < 95 ? ACT_QUERY : ACT_NOP;
			p = $urandom_range(0, 99);
			if (p < 10) rq = '0;
			else if (p < 25) rq = 16'($urandom);
			else rq = 16'($urandom_range(0, span / 4 > 65535 ? 65535 : span / 4));
			if ($urandom_range(0, 99) < 75)
				of = 16'($urandom_range(0, span + 31 > 65535 ? 65535 : span + 31));
			else
				of = 16'($urandom);
			send_word(act, rq, of, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		heap_rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			idle_cycles = 0;
			words_got++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response word st=%0d", rsp_ch.status);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.status !== want.st || rsp_ch.block_offset !== want.boff ||
						rsp_ch.block_bytes !== want.bbytes ||
						rsp_ch.free_granules !== want.freeg) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d off=%0d bytes=%0d free=%0d, ",
							want.st, want.boff, want.bbytes, want.freeg,
							"got st=%0d off=%0d bytes=%0d free=%0d", rsp_ch.status,
							rsp_ch.block_offset, rsp_ch.block_bytes, rsp_ch.free_granules);
				end
			end
		end
	end

	initial begin
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		gap = 0;
		forever begin
			@(posedge clk);
			if (stall_cycles > 0) begin
				stall_cycles--;
				rsp_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				gap = gap_len();
				rsp_ch.ready <= (gap == 0);
			end
		end
	end

	always @(posedge clk) begin
		idle_cycles++;
		if (idle_cycles > 3000) begin
			$display("tb: failure");
			$finish;
		end
	end

	step_row_t steps [] = '{
		'{0, ACT_QUERY, 16'd0, 16'd0, 1, '{ST_OK, 16'd0, 17'd65536, 13'd4096}},
		'{0, ACT_ALLOC, 16'd0, 16'd0, 1, '{ST_OK, 16'd0, 17'd16, 13'd4095}},
		'{0, ACT_ALLOC, 16'hFFFF, 16'd0, 1, '{ST_NO_FIT, 16'd0, 17'd0, 13'd4095}},
		'{0, ACT_ALLOC, 16'd1, 16'd0, 1, '{ST_OK, 16'd16, 17'd16, 13'd4094}},
		'{0, ACT_FREE, 16'd0, 16'hFFFF, 1, '{ST_OK, 16'd0, 17'd0, 13'd4094}},
		'{0, ACT_NOP, 16'hFFFF, 16'hFFFF, 1, '{ST_OK, 16'd0, 17'd0, 13'd4094}},
		'{0, ACT_FREE, 16'd0, 16'd0, 1, '{ST_OK, 16'd0, 17'd0, 13'd4095}},
		'{0, ACT_ALLOC, 16'd17, 16'd0, 0, '0},
		'{0, ACT_FREE, 16'd0, 16'd20, 0, '0},
		'{0, ACT_QUERY, 16'd0, 16'd16, 0, '0},
		'{0, ACT_ALLOC, 16'd65520, 16'd0, 0, '0},
		'{0, ACT_FREE, 16'd0, 16'd32, 0, '0},
		'{1, ACT_NOP, 16'd0, 16'd0, 0, '0},
		'{0, ACT_QUERY, 16'd0, 16'd16, 1, '{ST_NOT_FOUND, 16'd0, 17'd0, 13'd1}},
		'{0, ACT_ALLOC, 16'd16, 16'd0, 1, '{ST_OK, 16'd0, 17'd16, 13'd0}},
		'{0, ACT_ALLOC, 16'd0, 16'd0, 1, '{ST_NO_FIT, 16'd0, 17'd0, 13'd0}},
		'{0, ACT_FREE, 16'd0, 16'd15, 1, '{ST_OK, 16'd0, 17'd0, 13'd1}},
		'{0, ACT_FREE, 16'd0, 16'hFFFF, 1, '{ST_NOT_FOUND, 16'd0, 17'd0, 13'd1}},
		'{1, ACT_NOP, 16'h1FFF, 16'd0, 0, '0},
		'{0, ACT_ALLOC, 16'hFFFF, 16'd0, 1, '{ST_OK, 16'd0, 17'd65536, 13'd0}},
		'{0, ACT_QUERY, 16'd0, 16'hFFF0, 1, '{ST_OK, 16'd0, 17'd65536, 13'd0}},
		'{0, ACT_FREE, 16'd0, 16'h8000, 1, '{ST_OK, 16'd0, 17'd0, 13'd4096}}
	};

	initial begin
		req_ch.valid = 1'b0;
		req_ch.action = ACT_NOP;
		req_ch.request_bytes = '0;
		req_ch.offset = '0;
		heap_reinit(4096);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].wr_cfg)
				write_heap(steps[i].rq);
			else
				send_word(steps[i].act, steps[i].rq, steps[i].of, steps[i].typed,
					steps[i].rsp);
		end

		write_heap(4096);
		for (int i = 0; i < 64; i++)
			send_word(ACT_ALLOC, 16'd16, 16'd0, 1'b0, '0);

		random_phase(4096, 200);
		no_gaps = 1;
		random_phase(64, 150);
		no_gaps = 0;
		stall_cycles = 400;
		random_phase(300, 200);
		random_phase(1, 60);
		random_phase(32'h1FFF, 200);
		no_gaps = 1;
		random_phase($urandom_range(1, 4096), 200);
		no_gaps = 0;
		random_phase(2000, 300);

		wait_idle();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
